[src/llbm_pkg.sv]
// shared types, codes and bulb mapping tables for the snowflake bulb mapper
package llbm_pkg;

  // layout register codes (code 7 is unused and maps as linear)
  typedef enum logic [2:0] {
    LAYOUT_LINEAR   = 3'd0,
    LAYOUT_CW       = 3'd1,
    LAYOUT_RINGS    = 3'd2,
    LAYOUT_BLADES   = 3'd3,
    LAYOUT_LINES    = 3'd4,
    LAYOUT_CENTER   = 3'd5,
    LAYOUT_REDUCED  = 3'd6
  } llbm_layout_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } llbm_state_t;

  // how the current bulb advances between beats of a run
  typedef enum logic [1:0] {
    STEP_SHIFT = 2'd0,
    STEP_ADD1  = 2'd1,
    STEP_ADD10 = 2'd2
  } llbm_step_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic push;
  } llbm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_empty;
    logic last_beat;
    logic out_free;
  } llbm_sts_t;

  // one table row: entry count and bulbs in emit order
  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][5:0] bulb;
  } llbm_row_t;

  localparam int unsigned CW_COUNT     = 61;
  localparam int unsigned RING_COUNT   = 11;
  localparam int unsigned RING_LENGTH  = 6;
  localparam int unsigned RING_STEP    = 10;
  localparam int unsigned BLADE_COUNT  = 6;
  localparam int unsigned BLADE_LENGTH = 10;

  // clockwise order: blades walked in reverse
  function automatic logic [5:0] cw_bulb(input logic [5:0] v);
    logic [6:0] x;
    x = {1'b0, v};
    case (v) inside
      [6'd11:6'd20]: x = x + 7'd40;
      [6'd21:6'd30]: x = x + 7'd20;
      [6'd41:6'd50]: x = x - 7'd20;
      [6'd51:6'd60]: x = x - 7'd40;
      default:       x = {1'b0, v};
    endcase
    return x[5:0];
  endfunction

  // straight lines across the flake
  function automatic llbm_row_t line_row(input logic [5:0] v);
    llbm_row_t r;
    r = '0;
    case (v) inside
      [6'd0:6'd10]: begin
        r.n = 3'd1;
        r.bulb[0] = 6'd10 - v;
      end
      [6'd11:6'd20]: begin
        r.n = 3'd2;
        r.bulb[0] = v;
        r.bulb[1] = v + 6'd40;
      end
      [6'd21:6'd30]: begin
        r.n = 3'd2;
        r.bulb[0] = v;
        r.bulb[1] = v + 6'd20;
      end
      [6'd31:6'd40]: begin
        r.n = 3'd1;
        r.bulb[0] = v;
      end
      default: r.n = 3'd0;
    endcase
    return r;
  endfunction

  // lines through the center
  function automatic llbm_row_t center_row(input logic [5:0] v);
    llbm_row_t r;
    r = '0;
    case (v) inside
      6'd0: begin
        r.n = 3'd1;
        r.bulb[0] = 6'd0;
      end
      [6'd1:6'd10]: begin
        r.n = 3'd4;
        r.bulb[0] = v + 6'd10;
        r.bulb[1] = v + 6'd20;
        r.bulb[2] = v + 6'd40;
        r.bulb[3] = v + 6'd50;
      end
      [6'd11:6'd20]: begin
        r.n = 3'd2;
        r.bulb[0] = v - 6'd10;
        r.bulb[1] = v + 6'd20;
      end
      default: r.n = 3'd0;
    endcase
    return r;
  endfunction

  // reduced set: eight rows per blade, tip pairs merged
  function automatic llbm_row_t reduced_row(input logic [5:0] v);
    llbm_row_t  r;
    logic [5:0] k;
    logic [5:0] base;
    r = '0;
    k = v - 6'd1;
    base = {k[5:3], 3'b000} + {2'b00, k[5:3], 1'b0};
    case (v) inside
      6'd0: begin
        r.n = 3'd1;
        r.bulb[0] = 6'd0;
      end
      [6'd1:6'd48]: begin
        r.n = 3'd1;
        case (k[2:0])
          3'd0: r.bulb[0] = base + 6'd1;
          3'd1: r.bulb[0] = base + 6'd2;
          3'd2: r.bulb[0] = base + 6'd3;
          3'd3: r.bulb[0] = base + 6'd4;
          3'd4: begin
            r.n = 3'd2;
            r.bulb[0] = base + 6'd5;
            r.bulb[1] = base + 6'd7;
          end
          3'd5: r.bulb[0] = base + 6'd6;
          3'd6: begin
            r.n = 3'd2;
            r.bulb[0] = base + 6'd8;
            r.bulb[1] = base + 6'd10;
          end
          3'd7: r.bulb[0] = base + 6'd9;
          default: r.bulb[0] = base;
        endcase
      end
      default: r.n = 3'd0;
    endcase
    return r;
  endfunction

endpackage

[src/llbm_ctrl.sv]
// controller state machine: takes one command, then walks its run of beats
module llbm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  llbm_pkg::llbm_sts_t   sts,
  output llbm_pkg::llbm_cmd_t   cmd
);

  llbm_pkg::llbm_state_t state_r;
  llbm_pkg::llbm_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= llbm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      llbm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (!sts.item_empty) begin
            state_nxt = llbm_pkg::ST_EMIT;
          end
        end
      end
      llbm_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          if (sts.last_beat) begin
            state_nxt = llbm_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = llbm_pkg::ST_IDLE;
    endcase
  end

endmodule

[src/llbm_dp.sv]
// datapath: layout register, run setup from the tables, bulb stepper, output register
module llbm_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [2:0]            cfg_wr_data,
  input  logic [5:0]            virtual_bulb,
  input  logic [7:0]            intensity,
  input  logic [11:0]           colour,
  input  llbm_pkg::llbm_cmd_t   cmd,
  output llbm_pkg::llbm_sts_t   sts,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [5:0]            phys_bulb,
  output logic [7:0]            out_intensity,
  output logic [11:0]           out_colour,
  output logic                  out_last
);

  logic [2:0]            layout_r;
  logic [5:0]            bulb_r;
  logic [5:0]            bulb_nxt;
  logic [2:0][5:0]       rest_r;
  logic [3:0]            cnt_r;
  logic [3:0]            cnt_nxt;
  llbm_pkg::llbm_step_t  step_r;
  logic [7:0]            inten_r;
  logic [11:0]           colour_r;
  logic                  out_valid_r;
  logic [5:0]            out_bulb_r;
  logic [7:0]            out_inten_r;
  logic [11:0]           out_colour_r;
  logic                  out_last_r;

  // run setup for the incoming command
  llbm_pkg::llbm_row_t   row;
  llbm_pkg::llbm_step_t  step_ld;
  logic [3:0]            cnt_ld;

  // layout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r <= 3'd0;
    end else if (cfg_wr_en) begin
      layout_r <= cfg_wr_data;
    end
  end

  // map the command to its first bulb, run length and step kind
  always_comb begin
    row      = '0;
    step_ld  = llbm_pkg::STEP_SHIFT;
    cnt_ld   = 4'd0;
    case (llbm_pkg::llbm_layout_t'(layout_r))
      llbm_pkg::LAYOUT_CW: begin
        if (virtual_bulb < 6'(llbm_pkg::CW_COUNT)) begin
          row.bulb[0] = llbm_pkg::cw_bulb(virtual_bulb);
          cnt_ld      = 4'd1;
        end
      end
      llbm_pkg::LAYOUT_RINGS: begin
        step_ld     = llbm_pkg::STEP_ADD10;
        row.bulb[0] = virtual_bulb;
        if (virtual_bulb < 6'(llbm_pkg::RING_COUNT)) begin
          cnt_ld = (virtual_bulb == 6'd0) ? 4'd1 : 4'(llbm_pkg::RING_LENGTH);
        end
      end
      llbm_pkg::LAYOUT_BLADES: begin
        step_ld     = llbm_pkg::STEP_ADD1;
        row.bulb[0] = {virtual_bulb[2:0], 3'b000} + {2'b00, virtual_bulb[2:0], 1'b0} + 6'd1;
        if (virtual_bulb < 6'(llbm_pkg::BLADE_COUNT)) begin
          cnt_ld = 4'(llbm_pkg::BLADE_LENGTH);
        end
      end
      llbm_pkg::LAYOUT_LINES: begin
        row    = llbm_pkg::line_row(virtual_bulb);
        cnt_ld = {1'b0, row.n};
      end
      llbm_pkg::LAYOUT_CENTER: begin
        row    = llbm_pkg::center_row(virtual_bulb);
        cnt_ld = {1'b0, row.n};
      end
      llbm_pkg::LAYOUT_REDUCED: begin
        row    = llbm_pkg::reduced_row(virtual_bulb);
        cnt_ld = {1'b0, row.n};
      end
      default: begin
        row.bulb[0] = virtual_bulb;
        cnt_ld      = 4'd1;
      end
    endcase
  end

  // next bulb of the run
  always_comb begin
    case (step_r)
      llbm_pkg::STEP_ADD1:  bulb_nxt = bulb_r + 6'd1;
      llbm_pkg::STEP_ADD10: bulb_nxt = bulb_r + 6'(llbm_pkg::RING_STEP);
      default:              bulb_nxt = rest_r[0];
    endcase
    cnt_nxt = cnt_r - 4'd1;
  end

  // run counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else if (cmd.load) begin
      cnt_r <= cnt_ld;
    end else if (cmd.push) begin
      cnt_r <= cnt_nxt;
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bulb_r   <= row.bulb[0];
      rest_r   <= row.bulb[3:1];
      step_r   <= step_ld;
      inten_r  <= intensity;
      colour_r <= colour;
    end else if (cmd.push) begin
      bulb_r <= bulb_nxt;
      rest_r <= {6'd0, rest_r[2:1]};
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_bulb_r   <= bulb_r;
      out_inten_r  <= inten_r;
      out_colour_r <= colour_r;
      out_last_r   <= (cnt_r == 4'd1);
    end
  end

  // status to the controller
  assign sts.item_empty = (cnt_ld == 4'd0);
  assign sts.last_beat  = (cnt_r == 4'd1);
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid    = out_valid_r;
  assign phys_bulb     = out_bulb_r;
  assign out_intensity = out_inten_r;
  assign out_colour    = out_colour_r;
  assign out_last      = out_last_r;

endmodule

[src/led_layout_bulb_mapper_core.sv]
// Snowflake bulb mapper top level. Each input beat carries one colour command for a
// virtual bulb; the layout register picks how it maps onto the 61 physical bulbs, and the
// block emits the run of physical-bulb beats (0 to 10) with out_tlast on the final one.
// An index out of range for the layout gives no output beat. One command is handled at a
// time: the command is loaded first, then its run is walked beat by beat, and an empty run
// returns straight to idle. The run stepper hands one bulb per cycle to the output
// register while that register is free (out_tready stalls it); the next command is
// accepted while the last beat of a run still waits in that register. Write the layout
// only while no run is in progress.
module led_layout_bulb_mapper_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // virtual_bulb[5:0], intensity[13:6], colour[25:14], zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // phys_bulb[5:0], out_intensity[13:6],
                                  // out_colour[25:14], zero
  output logic        out_tlast
);

  llbm_pkg::llbm_cmd_t cmd;
  llbm_pkg::llbm_sts_t sts;
  logic [5:0]          phys_bulb;
  logic [7:0]          out_intensity;
  logic [11:0]         out_colour;

  // sequencer
  llbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // mapping datapath
  llbm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .virtual_bulb  (in_tdata[5:0]),
    .intensity     (in_tdata[13:6]),
    .colour        (in_tdata[25:14]),
    .cmd           (cmd),
    .sts           (sts),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .phys_bulb     (phys_bulb),
    .out_intensity (out_intensity),
    .out_colour    (out_colour),
    .out_last      (out_tlast)
  );

  // result beat packing
  assign out_tdata = {6'd0, out_colour, out_intensity, phys_bulb};

endmodule

[src/llbm_checker.sv]
// port-level checks for the snowflake bulb mapper, bound to the top level
module llbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // while taking commands, only the final beat of a run may be pending
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("command accepted with a run still pending");

  // a run continues without gaps while the sink keeps taking beats
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a run");

  // a stalled beat holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled beat changed");

endmodule

bind led_layout_bulb_mapper_core llbm_checker u_llbm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[verif/tb_top.sv]
// self-checking testbench for the snowflake bulb mapper: directed rows, then random layouts
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         HALF_PERIOD     = 5;
  localparam logic [2:0] LAYOUT_SPARE    = 3'd7;   // unused code, maps as linear
  localparam int         LINE_ROWS       = 41;
  localparam int         CENTER_ROWS     = 21;
  localparam int         REDUCED_ROWS    = 49;
  localparam int         ALL_BULBS       = 64;
  localparam int         MAX_GAP         = 4;
  localparam int         LONG_HOLD       = 80;
  localparam int         SETTLE_CYCLES   = 12;
  localparam int         IDLE_LIMIT      = 2000;
  localparam int         ITEMS_PER_PHASE = 40;
  localparam int         NUM_PHASES      = 10;
  localparam int         MAX_REPORTS     = 10;

  // one physical-bulb beat as it should leave the block
  typedef struct {
    logic [5:0]  bulb;
    logic [7:0]  intensity;
    logic [11:0] colour;
    logic        last;
  } bulb_beat_t;

  // one directed command, optionally with its outcome written out
  typedef struct {
    logic [2:0]  layout;
    logic [5:0]  vbulb;
    logic [7:0]  intensity;
    logic [11:0] colour;
    bit          typed;
    int          typed_n;
    logic [5:0]  typed_bulb;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;    // virtual_bulb[5:0], intensity[13:6], colour[25:14], zero
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;   // phys_bulb[5:0], out_intensity[13:6], out_colour[25:14], zero
  logic        out_tlast;

  logic [2:0]  layout_shadow;
  bulb_beat_t  pending_bulbs[$];
  int          error_cnt     = 0;
  int          commands_sent = 0;
  int          beats_checked = 0;
  int          layout_writes = 0;
  int          idle_cycles   = 0;
  bit          steady        = 1'b0;
  bit          hold_request  = 1'b0;

  led_layout_bulb_mapper_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void report_error(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  // number of valid indexes for a layout
  function automatic int index_span(input logic [2:0] layout);
    case (layout)
      llbm_pkg::LAYOUT_CW:      return llbm_pkg::CW_COUNT;
      llbm_pkg::LAYOUT_RINGS:   return llbm_pkg::RING_COUNT;
      llbm_pkg::LAYOUT_BLADES:  return llbm_pkg::BLADE_COUNT;
      llbm_pkg::LAYOUT_LINES:   return LINE_ROWS;
      llbm_pkg::LAYOUT_CENTER:  return CENTER_ROWS;
      llbm_pkg::LAYOUT_REDUCED: return REDUCED_ROWS;
      default:                  return ALL_BULBS;
    endcase
  endfunction

  // expected run of physical bulbs for one command, queued in emit order
  function automatic void map_virtual_bulb(input logic [2:0] layout, input logic [5:0] vbulb,
                                           input logic [7:0] intensity,
                                           input logic [11:0] colour);
    int         v;
    int         blade;
    int         pos;
    int         base;
    int         bulbs[$];
    bulb_beat_t b;
    v = vbulb;
    case (layout)
      llbm_pkg::LAYOUT_CW: begin
        // blades 1..5 are walked in reverse order
        if (v == 0) begin
          bulbs.push_back(0);
        end else if (v < llbm_pkg::CW_COUNT) begin
          blade = (v - 1) / 10;
          pos = (v - 1) % 10;
          bulbs.push_back(1 + 10 * ((6 - blade) % 6) + pos);
        end
      end
      llbm_pkg::LAYOUT_RINGS: begin
        if (v == 0) begin
          bulbs.push_back(0);
        end else if (v < llbm_pkg::RING_COUNT) begin
          for (int i = 0; i < llbm_pkg::RING_LENGTH; i++)
            bulbs.push_back(v + llbm_pkg::RING_STEP * i);
        end
      end
      llbm_pkg::LAYOUT_BLADES: begin
        if (v < llbm_pkg::BLADE_COUNT) begin
          for (int i = 0; i < llbm_pkg::BLADE_LENGTH; i++) bulbs.push_back(1 + 10 * v + i);
        end
      end
      llbm_pkg::LAYOUT_LINES: begin
        if (v <= 10) begin
          bulbs.push_back(10 - v);
        end else if (v <= 20) begin
          bulbs.push_back(v);
          bulbs.push_back(v + 40);
        end else if (v <= 30) begin
          bulbs.push_back(v);
          bulbs.push_back(v + 20);
        end else if (v < LINE_ROWS) begin
          bulbs.push_back(v);
        end
      end
      llbm_pkg::LAYOUT_CENTER: begin
        if (v == 0) begin
          bulbs.push_back(0);
        end else if (v <= 10) begin
          bulbs.push_back(v + 10);
          bulbs.push_back(v + 20);
          bulbs.push_back(v + 40);
          bulbs.push_back(v + 50);
        end else if (v < CENTER_ROWS) begin
          bulbs.push_back(v - 10);
          bulbs.push_back(v + 20);
        end
      end
      llbm_pkg::LAYOUT_REDUCED: begin
        // eight rows per blade, two of them light a pair
        if (v == 0) begin
          bulbs.push_back(0);
        end else if (v < REDUCED_ROWS) begin
          base = 10 * ((v - 1) / 8) + 1;
          pos = (v - 1) % 8;
          case (pos)
            4: begin
              bulbs.push_back(base + 4);
              bulbs.push_back(base + 6);
            end
            5: bulbs.push_back(base + 5);
            6: begin
              bulbs.push_back(base + 7);
              bulbs.push_back(base + 9);
            end
            7: bulbs.push_back(base + 8);
            default: bulbs.push_back(base + pos);
          endcase
        end
      end
      default: bulbs.push_back(v);
    endcase
    foreach (bulbs[i]) begin
      b.bulb = 6'(bulbs[i]);
      b.intensity = intensity;
      b.colour = colour;
      b.last = (i == bulbs.size() - 1);
      pending_bulbs.push_back(b);
    end
  endfunction

  function automatic stim_row_t directed_row(input logic [2:0] layout, input int vbulb,
                                             input logic [7:0] intensity,
                                             input logic [11:0] colour, input bit typed,
                                             input int typed_n, input int typed_bulb);
    stim_row_t r;
    r.layout = layout;
    r.vbulb = 6'(vbulb);
    r.intensity = intensity;
    r.colour = colour;
    r.typed = typed;
    r.typed_n = typed_n;
    r.typed_bulb = 6'(typed_bulb);
    return r;
  endfunction

  // drive one command beat and queue its expected bulbs once accepted
  task automatic offer_command(input logic [5:0] vbulb, input logic [7:0] intensity,
                               input logic [11:0] colour, input bit typed, input int typed_n,
                               input logic [5:0] typed_bulb);
    int         gap;
    bulb_beat_t b;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, colour, intensity, vbulb};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    commands_sent++;
    if (typed) begin
      repeat (typed_n) begin
        b.bulb = typed_bulb;
        b.intensity = intensity;
        b.colour = colour;
        b.last = 1'b1;
        pending_bulbs.push_back(b);
      end
    end else begin
      map_virtual_bulb(layout_shadow, vbulb, intensity, colour);
    end
  endtask

  // stop sending and let every expected beat come out, plus a margin for empty runs
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_bulbs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_layout(input logic [2:0] code);
    wait_drained();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    layout_shadow = code;
    layout_writes++;
  endtask

  // output side: random back-pressure, one long hold on request
  initial begin : receiver
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // compare every output beat with the oldest expectation
  always @(posedge clk) begin
    bulb_beat_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_tvalid && out_tready) begin
        if (pending_bulbs.size() == 0) begin
          report_error($sformatf("unexpected beat: bulb %0d int %0d col %03h last %0b",
                                 out_tdata[5:0], out_tdata[13:6], out_tdata[25:14],
                                 out_tlast));
        end else begin
          want = pending_bulbs.pop_front();
          beats_checked++;
          if (out_tdata[5:0] !== want.bulb || out_tdata[13:6] !== want.intensity ||
              out_tdata[25:14] !== want.colour || out_tdata[31:26] !== 6'd0 ||
              out_tlast !== want.last)
            report_error($sformatf({"layout %0d: want bulb %0d int %0d col %03h last %0b, ",
                                    "got bulb %0d int %0d col %03h pad %0h last %0b"},
                                   layout_shadow, want.bulb, want.intensity, want.colour,
                                   want.last, out_tdata[5:0], out_tdata[13:6],
                                   out_tdata[25:14], out_tdata[31:26], out_tlast));
        end
      end
    end
  end

  // no handshake for too long means the block hung
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    stim_row_t  rows[$];
    logic [2:0] phase_layouts [NUM_PHASES];
    int         span;
    int         counted;
    bit         stray;
    logic [5:0] v;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = llbm_pkg::LAYOUT_LINEAR;
    in_tvalid = 1'b0;
    in_tdata = '0;
    layout_shadow = llbm_pkg::LAYOUT_LINEAR;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset layout, index extremes, out-of-range indexes, ring 0, spare code
    rows.push_back(directed_row(llbm_pkg::LAYOUT_LINEAR,  0,  8'h00, 12'h000, 1, 1, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_LINEAR,  63, 8'hFF, 12'hFFF, 1, 1, 63));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_CW,      0,  8'h5A, 12'hA5A, 1, 1, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_CW,      60, 8'hA5, 12'h5A5, 1, 1, 20));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_CW,      61, 8'hFF, 12'hFFF, 1, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_CW,      11, 8'h12, 12'h345, 0, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_RINGS,   0,  8'h80, 12'h800, 1, 1, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_RINGS,   10, 8'h01, 12'h001, 0, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_RINGS,   11, 8'h00, 12'h000, 1, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_BLADES,  0,  8'hFF, 12'hFFF, 0, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_BLADES,  5,  8'h00, 12'h000, 0, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_BLADES,  6,  8'h33, 12'h333, 1, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_LINES,   0,  8'h44, 12'h444, 1, 1, 10));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_LINES,   11, 8'h55, 12'h555, 0, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_LINES,   40, 8'h66, 12'h666, 1, 1, 40));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_LINES,   41, 8'h77, 12'h777, 1, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_CENTER,  0,  8'h88, 12'h888, 1, 1, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_CENTER,  1,  8'h99, 12'h999, 0, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_CENTER,  20, 8'hAA, 12'hAAA, 0, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_CENTER,  63, 8'hBB, 12'hBBB, 1, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_REDUCED, 0,  8'hCC, 12'hCCC, 1, 1, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_REDUCED, 5,  8'hDD, 12'hDDD, 0, 0, 0));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_REDUCED, 48, 8'hEE, 12'hEEE, 1, 1, 59));
    rows.push_back(directed_row(llbm_pkg::LAYOUT_REDUCED, 49, 8'hFF, 12'hFFF, 1, 0, 0));
    rows.push_back(directed_row(LAYOUT_SPARE,             63, 8'h0F, 12'hF0F, 1, 1, 63));
    rows.push_back(directed_row(LAYOUT_SPARE,             30, 8'hF0, 12'h0F0, 0, 0, 0));
    foreach (rows[i]) begin
      if (rows[i].layout != layout_shadow) write_layout(rows[i].layout);
      offer_command(rows[i].vbulb, rows[i].intensity, rows[i].colour, rows[i].typed,
                    rows[i].typed_n, rows[i].typed_bulb);
    end

    // random: one layout per phase, mostly valid indexes with a few out of range
    phase_layouts = '{llbm_pkg::LAYOUT_BLADES, llbm_pkg::LAYOUT_REDUCED, llbm_pkg::LAYOUT_CW,
                      llbm_pkg::LAYOUT_RINGS, llbm_pkg::LAYOUT_LINES, LAYOUT_SPARE,
                      llbm_pkg::LAYOUT_CENTER, llbm_pkg::LAYOUT_LINEAR,
                      llbm_pkg::LAYOUT_BLADES, llbm_pkg::LAYOUT_CENTER};
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_layout(phase_layouts[p]);
      steady = (p == 3 || p == 8);
      if (p == 0) hold_request = 1'b1;
      span = index_span(layout_shadow);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        stray = (span < ALL_BULBS) && ($urandom_range(0, 9) == 0);
        v = 6'(stray ? $urandom_range(span, ALL_BULBS - 1) : $urandom_range(0, span - 1));
        offer_command(v, 8'($urandom), 12'($urandom), 1'b0, 0, 6'd0);
        if (!stray) counted++;
        // pause mid-phase until the output side has caught up
        if (p == 6 && !stray && counted == ITEMS_PER_PHASE / 2) wait_drained();
      end
    end
    steady = 1'b0;

    wait_drained();
    $display("tb: %0d commands over %0d layout writes, %0d bulb beats compared",
             commands_sent, layout_writes, beats_checked);
    $display("tb: all eight layout codes, stray indexes, a long output hold and a drain pause");
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", error_cnt);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
